/* hdl/ttcg_pkg.sv */
// ttcg_pkg: shared types, register indexes and band constants of the
// thermal throttle and core gate block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttcg_pkg;

  localparam int TEMP_W  = 9;
  localparam int TIME_W  = 64;
  localparam int FREQ_W  = 32;
  localparam int MASK_W  = 8;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 32;
  localparam int IN_W    = 80;  // 9 + 64 bits, padded to whole bytes
  localparam int OUT_W   = 48;  // 32 + 1 + 1 + 8 bits, padded to whole bytes

  typedef enum logic [CIDX_W-1:0] {
    REG_TRIP_TEMP     = 3'd0,
    REG_HYSTERESIS    = 3'd1,
    REG_HOT_CAP       = 3'd2,
    REG_FULL_FREQ     = 3'd3,
    REG_MIN_HOLD_US   = 3'd4,
    REG_CORE_GATE_EN  = 3'd5
  } reg_idx_t;

  localparam logic [7:0]        TRIP_TEMP_RST     = 8'd65;
  localparam logic [7:0]        HYSTERESIS_RST    = 8'd5;
  localparam logic [FREQ_W-1:0] HOT_CAP_RST       = 32'd800000;
  localparam logic [FREQ_W-1:0] FULL_FREQ_RST     = 32'hFFFF_FFFF;
  localparam logic [FREQ_W-1:0] MIN_HOLD_US_RST   = 32'd1000000;
  localparam logic [MASK_W-1:0] MASK_ALL_ON       = 8'hFF;

  // temperature bands for core gating
  localparam logic signed [TEMP_W:0] BAND_HOT_LO  = 10'sd81;
  localparam logic signed [TEMP_W:0] BAND_WARM_LO = 10'sd60;
  localparam logic signed [TEMP_W:0] BAND_WARM_HI = 10'sd80;
  localparam logic signed [TEMP_W:0] BAND_MILD_LO = 10'sd49;
  localparam logic signed [TEMP_W:0] BAND_MILD_HI = 10'sd59;
  localparam logic signed [TEMP_W:0] BAND_ALL_ON  = 10'sd45;

  localparam logic [MASK_W-1:0] HOT_SET   = 8'h01;
  localparam logic [MASK_W-1:0] HOT_CLR   = 8'hCE;
  localparam logic [MASK_W-1:0] WARM_SET  = 8'hC0;
  localparam logic [MASK_W-1:0] WARM_CLR  = 8'h0E;
  localparam logic [MASK_W-1:0] MILD_SET  = 8'h03;
  localparam logic [MASK_W-1:0] MILD_CLR  = 8'h0C;

  typedef struct packed {
    logic [7:0]        trip_temp;
    logic [7:0]        hysteresis;
    logic [FREQ_W-1:0] hot_cap;
    logic [FREQ_W-1:0] full_freq;
    logic [FREQ_W-1:0] min_hold_us;
    logic              core_gate_enable;
  } cfg_t;

  typedef struct packed {
    logic              throttle_flag;
    logic [FREQ_W-1:0] cap_value;
    logic [TIME_W-1:0] cap_time;
    logic [MASK_W-1:0] online_mask;
  } state_t;

  typedef struct packed {
    logic [MASK_W-1:0] core_mask;
    logic              is_throttling;
    logic              cap_changed;
    logic [FREQ_W-1:0] freq_cap;
  } result_t;

endpackage

`default_nettype wire

/* hdl/thermal_throttle_core_gate_top.sv */
// thermal_throttle_core_gate_top: poll input register, update logic, result register
// and configuration registers. Depends on ttcg_pkg and ttcg_step.
//
//  channel | dir | handshake            | payload
//  s_*     | in  | s_tvalid / s_tready  | s_tdata: temperature, now_us
//  m_*     | out | m_tvalid / m_tready  | m_tdata: freq_cap, cap_changed, is_throttling, core_mask
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one poll per cycle while results are taken; a result is offered once its beat has passed
// through the input register, then the result register fed by the combinational update logic
// throttle state updates as a poll moves into the result register
// a stalled result holds the input register, which still takes one more beat
// rst is synchronous and restores register and state reset values; cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module thermal_throttle_core_gate_top import ttcg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [IN_W-1:0]    s_tdata,   // [8:0] temperature, [72:9] now_us, rest zero
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [OUT_W-1:0]        m_tdata,   // [31:0] freq_cap, [32] cap_changed,
                                             // [33] is_throttling, [41:34] core_mask, rest zero
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_data
);

  cfg_t                     cfg;
  state_t                   st;
  state_t                   st_next;
  state_t                   st_upd;
  result_t                  res_next;
  result_t                  res;
  logic                     in_valid;
  logic signed [TEMP_W-1:0] in_temp;
  logic [TIME_W-1:0]        in_now;
  logic                     out_valid;
  logic                     advance;
  logic                     cfg_we;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  ttcg_step u_step (
    .cfg         (cfg),
    .cur         (st),
    .temperature (in_temp),
    .now_us      (in_now),
    .nxt         (st_next),
    .res         (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_temp <= $signed(s_tdata[TEMP_W-1:0]);
      in_now  <= s_tdata[TEMP_W+TIME_W-1:TEMP_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W-FREQ_W-2-MASK_W){1'b0}}, res.core_mask, res.is_throttling,
                     res.cap_changed, res.freq_cap};

  // gating switched off forces every core online
  always_comb begin
    st_upd = advance ? st_next : st;
    if (cfg_we && (cfg_index == REG_CORE_GATE_EN) && !cfg_data[0]) begin
      st_upd.online_mask = MASK_ALL_ON;
    end
  end

  // configuration and throttle state
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trip_temp        <= TRIP_TEMP_RST;
      cfg.hysteresis       <= HYSTERESIS_RST;
      cfg.hot_cap          <= HOT_CAP_RST;
      cfg.full_freq        <= FULL_FREQ_RST;
      cfg.min_hold_us      <= MIN_HOLD_US_RST;
      cfg.core_gate_enable <= 1'b1;
      st.throttle_flag     <= 1'b0;
      st.cap_value         <= {FREQ_W{1'b1}};
      st.cap_time          <= '0;
      st.online_mask       <= MASK_ALL_ON;
    end else begin
      st <= st_upd;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TRIP_TEMP:    cfg.trip_temp        <= cfg_data[7:0];
          REG_HYSTERESIS:   cfg.hysteresis       <= cfg_data[7:0];
          REG_HOT_CAP:      cfg.hot_cap          <= cfg_data;
          REG_FULL_FREQ:    cfg.full_freq        <= cfg_data;
          REG_MIN_HOLD_US:  cfg.min_hold_us      <= cfg_data;
          REG_CORE_GATE_EN: cfg.core_gate_enable <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  a_changed_matches_cap: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.cap_changed == (st.cap_value != $past(st.cap_value))))
    else $error("cap_changed disagrees with cap update");

  a_flag_matches_state: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res.is_throttling == st.throttle_flag))
    else $error("is_throttling disagrees with throttle state");

  a_mask_all_on_when_off: assert property (@(posedge clk) disable iff (rst)
    !cfg.core_gate_enable |-> (st.online_mask == MASK_ALL_ON))
    else $error("online mask not all on while gating is off");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty result register");

endmodule

`default_nettype wire

/* hdl/ttcg_step.sv */
// ttcg_step: combinational update for one poll; next state and result.
// Depends on ttcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ttcg_step import ttcg_pkg::*; (
  input  cfg_t                     cfg,
  input  state_t                   cur,
  input  logic signed [TEMP_W-1:0] temperature,
  input  logic [TIME_W-1:0]        now_us,
  output state_t                   nxt,
  output result_t                  res
);

  logic signed [TEMP_W:0] t_ext;
  logic signed [TEMP_W:0] trip_ext;
  logic signed [TEMP_W:0] rel;
  logic [TIME_W:0]        sum;
  logic [TIME_W-1:0]      deadline;
  logic                   cold;
  logic                   hot;
  logic                   skip_bands;
  logic [MASK_W-1:0]      m;
  logic                   changed;

  always_comb begin
    t_ext    = {temperature[TEMP_W-1], temperature};
    trip_ext = $signed({2'b00, cfg.trip_temp});
    rel      = trip_ext - $signed({2'b00, cfg.hysteresis});
    // saturating hold deadline
    sum      = {1'b0, cur.cap_time} + {{(TIME_W+1-FREQ_W){1'b0}}, cfg.min_hold_us};
    deadline = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
    cold       = cur.throttle_flag && (t_ext < rel);
    hot        = t_ext >= trip_ext;
    skip_bands = cold;

    nxt     = cur;
    changed = 1'b0;

    if (cold) begin
      if (now_us >= deadline) begin
        if (cur.cap_value != cfg.full_freq) begin
          nxt.cap_value = cfg.full_freq;
          nxt.cap_time  = now_us;
          changed       = 1'b1;
        end
        nxt.throttle_flag = 1'b0;
      end
    end else if (hot) begin
      if (cur.cap_value != cfg.hot_cap) begin
        nxt.cap_value = cfg.hot_cap;
        nxt.cap_time  = now_us;
        changed       = 1'b1;
      end
      nxt.throttle_flag = 1'b1;
    end

    m = cur.online_mask;
    priority if (t_ext >= BAND_HOT_LO) begin
      m = (m | HOT_SET) & ~HOT_CLR;
    end else if (t_ext >= BAND_WARM_LO && t_ext <= BAND_WARM_HI) begin
      m = (m | WARM_SET) & ~WARM_CLR;
    end else if (t_ext >= BAND_MILD_LO && t_ext <= BAND_MILD_HI) begin
      m = (m | MILD_SET) & ~MILD_CLR;
    end else if (t_ext == BAND_ALL_ON) begin
      m = MASK_ALL_ON;
    end else begin
      m = cur.online_mask;
    end
    if (!skip_bands && cfg.core_gate_enable) begin
      nxt.online_mask = m;
    end

    res.freq_cap      = nxt.cap_value;
    res.cap_changed   = changed;
    res.is_throttling = nxt.throttle_flag;
    res.core_mask     = cfg.core_gate_enable ? nxt.online_mask : MASK_ALL_ON;
  end

endmodule

`default_nettype wire
